@@ rtl/ectd_pkg.sv @@
package ectd_pkg;

	// Seconds per day split as 2^7 * 675; quotient estimate by reciprocal
	localparam int unsigned DayShift = 7;
	localparam logic [9:0]  DayOdd   = 10'd675;
	localparam logic [15:0] DayRecip = 16'd49710;   // floor(2^25 / 675)
	localparam int unsigned DayK     = 25;

	// Seconds per hour split as 2^4 * 225
	localparam logic [7:0]  HourOdd   = 8'd225;
	localparam logic [5:0]  HourRecip = 6'd36;      // floor(2^13 / 225)
	localparam int unsigned HourK     = 13;

	// Seconds per minute split as 2^2 * 15
	localparam logic [3:0]  MinOdd   = 4'd15;
	localparam logic [6:0]  MinRecip = 7'd68;       // floor(2^10 / 15)
	localparam int unsigned MinK     = 10;

	// Four-year cycles counted from 1968-03-01
	localparam logic [15:0] CycDays   = 16'd1461;
	localparam logic [5:0]  CycRecip  = 6'd44;      // floor(2^16 / 1461)
	localparam int unsigned CycK      = 16;
	localparam logic [15:0] EpochOfs  = 16'd671;    // 1968-03-01 to 1970-01-01
	localparam logic [15:0] Day2100   = 16'd47541;  // 2100-03-01 since the epoch
	localparam logic [11:0] BaseYear  = 12'd1968;
	localparam logic [8:0]  YearDays  = 9'd365;

	// First day of each month in a year that starts on 1 March
	function automatic logic [8:0] month_start(input logic [3:0] mp);
		logic [8:0] r;
		case (mp)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd61;
			4'd3:    r = 9'd92;
			4'd4:    r = 9'd122;
			4'd5:    r = 9'd153;
			4'd6:    r = 9'd184;
			4'd7:    r = 9'd214;
			4'd8:    r = 9'd245;
			4'd9:    r = 9'd275;
			4'd10:   r = 9'd306;
			4'd11:   r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/epoch_to_calendar_datetime.sv @@
// Converts a 32-bit count of seconds since 1970-01-01 00:00:00 into the
// Gregorian year, month, day, hour, minute and second. A beat is taken on
// every cycle in which start is high (busy is always low), and its result
// appears on done, for one cycle, from the fifth stage register; the receiver
// cannot stall it. The five-stage pipeline takes a new beat each cycle:
// stage one forms the day-count reciprocal product, stage two corrects the
// day count and seconds of day, stage three yields the hour and the
// four-year cycle estimate, stage four the minute, second and cycle
// remainder, and stage five the year, month and day. The leap rule covers
// the whole input range, including 2100 as a common year.
module epoch_to_calendar_datetime (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] epoch_seconds,
	output logic        done,
	output logic [11:0] year,
	output logic [3:0]  month,
	output logic [4:0]  day_of_month,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second
);

	// Pipeline valid bits
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	// Stage 1 registers
	logic [24:0] x_s1;
	logic [6:0]  lo_s1;
	logic [40:0] prod_s1;

	// Stage 2 registers
	logic [15:0] days_s2;
	logic [16:0] srem_s2;

	// Stage 3 registers
	logic [4:0]  hour_s3;
	logic [11:0] rest_s3;
	logic [15:0] z_s3;
	logic [5:0]  cyce_s3;

	// Stage 4 registers
	logic [4:0]  hour_s4;
	logic [5:0]  min_s4;
	logic [5:0]  sec_s4;
	logic [5:0]  cyc_s4;
	logic [10:0] crem_s4;

	// Stage 5 registers
	logic [11:0] year_s5;
	logic [3:0]  month_s5;
	logic [4:0]  day_s5;
	logic [4:0]  hour_s5;
	logic [5:0]  min_s5;
	logic [5:0]  sec_s5;

	// Stage 2 logic
	logic [15:0] dq_est;
	logic [25:0] dq_mul;
	logic [25:0] dr_raw;
	logic        dr_fix;
	logic [15:0] days_c;
	logic [9:0]  dr_c;

	// Stage 3 logic
	logic [12:0] hx;
	logic [18:0] hprod;
	logic [4:0]  hq_est;
	logic [12:0] hr_raw;
	logic        hr_fix;
	logic [4:0]  hour_c;
	logic [7:0]  hr_c;
	logic [15:0] z_c;
	logic [21:0] zprod;

	// Stage 4 logic
	logic [9:0]  mx;
	logic [16:0] mprod;
	logic [5:0]  mq_est;
	logic [9:0]  mr_raw;
	logic        mr_fix;
	logic [5:0]  min_c;
	logic [3:0]  mr_c;
	logic [15:0] cr_raw;
	logic        cr_fix;
	logic [5:0]  cyc_c;
	logic [10:0] cr_c;

	// Stage 5 logic
	logic [1:0]  yoe;
	logic [8:0]  doy;
	logic [3:0]  mp;
	logic [8:0]  dom;
	logic [3:0]  month_c;
	logic [11:0] year_c;

	// The pipeline never refuses a beat
	assign busy = 1'b0;

	// Advance the valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			valid_s1 <= start & ~busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// Stage 1: reciprocal product for the whole-day count
	always_ff @(posedge clk) begin
		x_s1    <= epoch_seconds[31:ectd_pkg::DayShift];
		lo_s1   <= epoch_seconds[ectd_pkg::DayShift-1:0];
		prod_s1 <= 41'(epoch_seconds[31:ectd_pkg::DayShift]) * 41'(ectd_pkg::DayRecip);
	end

	// Stage 2: correct the day estimate by one, form seconds of the day
	always_comb begin
		dq_est = prod_s1[40:ectd_pkg::DayK];
		dq_mul = 26'(dq_est) * 26'(ectd_pkg::DayOdd);
		dr_raw = 26'(x_s1) - dq_mul;
		dr_fix = dr_raw >= 26'(ectd_pkg::DayOdd);
		days_c = dr_fix ? dq_est + 16'd1 : dq_est;
		dr_c   = dr_fix ? 10'(dr_raw - 26'(ectd_pkg::DayOdd)) : dr_raw[9:0];
	end

	always_ff @(posedge clk) begin
		days_s2 <= days_c;
		srem_s2 <= {dr_c, lo_s1};
	end

	// Stage 3: hour of day, shifted day count and cycle estimate
	always_comb begin
		hx     = srem_s2[16:4];
		hprod  = 19'(hx) * 19'(ectd_pkg::HourRecip);
		hq_est = hprod[17:ectd_pkg::HourK];
		hr_raw = hx - 13'(hq_est) * 13'(ectd_pkg::HourOdd);
		hr_fix = hr_raw >= 13'(ectd_pkg::HourOdd);
		hour_c = hr_fix ? hq_est + 5'd1 : hq_est;
		hr_c   = hr_fix ? 8'(hr_raw - 13'(ectd_pkg::HourOdd)) : hr_raw[7:0];
		// Insert a phantom 29 February 2100 so the four-year cycle holds
		z_c    = days_s2 + ectd_pkg::EpochOfs
		         + ((days_s2 >= ectd_pkg::Day2100) ? 16'd1 : 16'd0);
		zprod  = 22'(z_c) * 22'(ectd_pkg::CycRecip);
	end

	always_ff @(posedge clk) begin
		hour_s3 <= hour_c;
		rest_s3 <= {hr_c, srem_s2[3:0]};
		z_s3    <= z_c;
		cyce_s3 <= zprod[21:ectd_pkg::CycK];
	end

	// Stage 4: minute, second and cycle remainder
	always_comb begin
		mx     = rest_s3[11:2];
		mprod  = 17'(mx) * 17'(ectd_pkg::MinRecip);
		mq_est = mprod[15:ectd_pkg::MinK];
		mr_raw = mx - 10'(mq_est) * 10'(ectd_pkg::MinOdd);
		mr_fix = mr_raw >= 10'(ectd_pkg::MinOdd);
		min_c  = mr_fix ? mq_est + 6'd1 : mq_est;
		mr_c   = mr_fix ? 4'(mr_raw - 10'(ectd_pkg::MinOdd)) : mr_raw[3:0];
		cr_raw = z_s3 - 16'(cyce_s3) * ectd_pkg::CycDays;
		cr_fix = cr_raw >= ectd_pkg::CycDays;
		cyc_c  = cr_fix ? cyce_s3 + 6'd1 : cyce_s3;
		cr_c   = cr_fix ? 11'(cr_raw - ectd_pkg::CycDays) : cr_raw[10:0];
	end

	always_ff @(posedge clk) begin
		hour_s4 <= hour_s3;
		min_s4  <= min_c;
		sec_s4  <= {mr_c, rest_s3[1:0]};
		cyc_s4  <= cyc_c;
		crem_s4 <= cr_c;
	end

	// Stage 5: year in cycle, month and day from a March-based year
	always_comb begin
		yoe = 2'd0;
		if (crem_s4 >= 11'(2 * ectd_pkg::YearDays)) begin
			yoe = 2'd1;
		end
		if (crem_s4 >= 11'(ectd_pkg::YearDays)) begin
			yoe = yoe + 2'd1;
		end
		if (crem_s4 >= 11'(3 * ectd_pkg::YearDays)) begin
			yoe = yoe + 2'd1;
		end
		doy = 9'(crem_s4 - 11'(yoe) * 11'(ectd_pkg::YearDays));
		mp  = 4'd0;
		for (int i = 1; i < 12; i++) begin
			if (doy >= ectd_pkg::month_start(4'(i))) begin
				mp = 4'(i);
			end
		end
		dom     = doy - ectd_pkg::month_start(mp) + 9'd1;
		month_c = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
		year_c  = ectd_pkg::BaseYear + {4'd0, cyc_s4, 2'b00} + 12'(yoe)
		          + ((mp >= 4'd10) ? 12'd1 : 12'd0);
	end

	always_ff @(posedge clk) begin
		year_s5  <= year_c;
		month_s5 <= month_c;
		day_s5   <= dom[4:0];
		hour_s5  <= hour_s4;
		min_s5   <= min_s4;
		sec_s5   <= sec_s4;
	end

	// Drive the result ports from the last stage
	assign done         = valid_s5;
	assign year         = year_s5;
	assign month        = month_s5;
	assign day_of_month = day_s5;
	assign hour         = hour_s5;
	assign minute       = min_s5;
	assign second       = sec_s5;

	// Every accepted beat comes out on done from the last stage
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##5 done)
		else $error("accepted beat did not emerge after five cycles");

	// No result without a matching earlier input beat
	a_no_ghost: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 5))
		else $error("result without matching input beat");

	// Date fields within calendar range
	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (month >= 4'd1 && month <= 4'd12 && day_of_month >= 5'd1
		          && year >= 12'd1970 && year <= 12'd2106))
		else $error("date field out of range");

	// Time fields within range
	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59))
		else $error("time field out of range");

endmodule

@@ dv/tb_epoch_to_calendar_datetime.sv @@
`timescale 1ns / 1ps

module tb_epoch_to_calendar_datetime;

	localparam int unsigned CYCLE_LIMIT  = 100000;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned ITEMS_PER_PHASE = 484;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} calendar_t;

	typedef struct packed {
		logic [31:0] secs;
		logic        known;
		calendar_t   date;
	} timestamp_row_t;

	localparam int N_DIRECTED = 24;

	// Known dates are typed in; the rest are worked out by the converter below
	localparam timestamp_row_t DIRECTED [N_DIRECTED] = '{
		'{32'd0,          1'b1, '{12'd1970, 4'd1, 5'd1,  5'd0, 6'd0,  6'd0}},
		'{32'd4294967295, 1'b1, '{12'd2106, 4'd2, 5'd7,  5'd6, 6'd28, 6'd15}},
		'{32'd2147483647, 1'b1, '{12'd2038, 4'd1, 5'd19, 5'd3, 6'd14, 6'd7}},
		'{32'd2147483648, 1'b0, '0},
		'{32'd1,          1'b0, '0},
		'{32'd59,         1'b0, '0},
		'{32'd60,         1'b0, '0},
		'{32'd3599,       1'b0, '0},
		'{32'd3600,       1'b0, '0},
		'{32'd86399,      1'b0, '0},
		'{32'd86400,      1'b0, '0},
		'{32'd31535999,   1'b0, '0},
		'{32'd31536000,   1'b0, '0},
		'{32'd68169600,   1'b0, '0},
		'{32'd946684799,  1'b0, '0},
		'{32'd946684800,  1'b0, '0},
		'{32'd951782400,  1'b0, '0},
		'{32'd951868799,  1'b0, '0},
		'{32'd951868800,  1'b0, '0},
		'{32'd4107542399, 1'b0, '0},
		'{32'd4107542400, 1'b0, '0},
		'{32'd4133980799, 1'b0, '0},
		'{32'hAAAAAAAA,   1'b0, '0},
		'{32'h55555555,   1'b0, '0}
	};

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [31:0] epoch_seconds;
	logic        done;
	logic [11:0] year;
	logic [3:0]  month;
	logic [4:0]  day_of_month;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;

	calendar_t   pending_dates[$];
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	epoch_to_calendar_datetime DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.epoch_seconds(epoch_seconds),
		.done         (done),
		.year         (year),
		.month        (month),
		.day_of_month (day_of_month),
		.hour         (hour),
		.minute       (minute),
		.second       (second)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic bit is_leap(input int unsigned y);
		return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
	endfunction

	function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
		case (m)
			2:           return is_leap(y) ? 29 : 28;
			4, 6, 9, 11: return 30;
			default:     return 31;
		endcase
	endfunction

	// Split seconds into time of day, then strip whole years and whole months
	function automatic calendar_t calendar_of(input logic [31:0] secs);
		calendar_t    c;
		int unsigned  days;
		int unsigned  y;
		int unsigned  m;
		int unsigned  ylen;
		c.second = 6'(secs % 60);
		c.minute = 6'((secs / 60) % 60);
		c.hour   = 5'((secs / 3600) % 24);
		days     = secs / 86400;
		y = 1970;
		ylen = is_leap(y) ? 366 : 365;
		while (days >= ylen) begin
			days -= ylen;
			y++;
			ylen = is_leap(y) ? 366 : 365;
		end
		m = 1;
		while (days >= days_in_month(y, m)) begin
			days -= days_in_month(y, m);
			m++;
		end
		c.year         = y[11:0];
		c.month        = m[3:0];
		c.day_of_month = days[4:0] + 5'd1;
		return c;
	endfunction

	// Seconds at midnight starting the given date
	function automatic longint midnight_of(input int unsigned y, input int unsigned m,
			input int unsigned d);
		longint      days;
		int unsigned k;
		days = 0;
		for (k = 1970; k < y; k++)
			days += is_leap(k) ? 366 : 365;
		for (k = 1; k < m; k++)
			days += days_in_month(y, k);
		days += d - 1;
		return days * 86400;
	endfunction

	// Mostly timestamps near day, month and year boundaries; the rest uniform
	function automatic logic [31:0] random_timestamp();
		int unsigned kind;
		int unsigned y;
		int unsigned m;
		int unsigned d;
		longint      t;
		kind = $urandom_range(9);
		if (kind < 3)
			return $urandom;
		if (kind < 7) begin
			y = $urandom_range(1970, 2106);
			m = $urandom_range(1, 12);
			d = $urandom_range(1) ? 1 : days_in_month(y, m);
		end else begin
			// End of February in years divisible by four, century years 2000 and 2100 included
			y = $urandom_range(3) == 0 ? ($urandom_range(1) ? 2000 : 2100)
				: 1972 + 4 * $urandom_range(0, 33);
			m = $urandom_range(2, 3);
			d = m == 3 ? 1 : $urandom_range(28, days_in_month(y, 2));
		end
		t = midnight_of(y, m, d);
		case ($urandom_range(2))
			0:       t += 86399;
			1:       t += $urandom_range(86399);
			default: t += 0;
		endcase
		t += longint'($urandom_range(4)) - 2;
		if (t < 0 || t > 64'hFFFF_FFFF)
			return $urandom;
		return t[31:0];
	endfunction

	// Present one beat, with an optional gap before it, and log what it must give
	task automatic send_timestamp(input logic [31:0] secs, input logic known,
			input calendar_t date, input int unsigned idle_pct);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start         <= 1'b0;
			epoch_seconds <= $urandom;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start         <= 1'b1;
		epoch_seconds <= secs;
		do
			@(posedge clk);
		while (busy);
		pending_dates.push_back(known ? date : calendar_of(secs));
	endtask

	task automatic check_field(input string name, input int unsigned expected,
			input int unsigned actual);
		if (expected != actual) begin
			$error("%s: expected %0d, got %0d", name, expected, actual);
			mismatches++;
		end
	endtask

	// Compare each returned beat with the oldest outstanding date
	always @(posedge clk) begin
		calendar_t want;
		if (arst_n && done) begin
			if (pending_dates.size() == 0) begin
				$error("result beat with no date outstanding");
				mismatches++;
			end else begin
				want = pending_dates.pop_front();
				check_field("year",         want.year,         year);
				check_field("month",        want.month,        month);
				check_field("day_of_month", want.day_of_month, day_of_month);
				check_field("hour",         want.hour,         hour);
				check_field("minute",       want.minute,       minute);
				check_field("second",       want.second,       second);
			end
		end
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_epoch_to_calendar_datetime NOT OK");
			$finish;
		end
	end

	initial begin
		int unsigned idle_pct [3];
		int          i;
		int          p;
		idle_pct      = '{20, 53, 0};
		arst_n        = 1'b0;
		start         = 1'b0;
		epoch_seconds = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table
		for (i = 0; i < N_DIRECTED; i++)
			send_timestamp(DIRECTED[i].secs, DIRECTED[i].known, DIRECTED[i].date, 0);

		// Random timestamps, sender gaps light, then heavy, then none
		for (p = 0; p < 3; p++)
			repeat (ITEMS_PER_PHASE)
				send_timestamp(random_timestamp(), 1'b0, '0, idle_pct[p]);

		start <= 1'b0;
		while (pending_dates.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && pending_dates.size() == 0)
			$display("tb_epoch_to_calendar_datetime OK");
		else
			$display("tb_epoch_to_calendar_datetime NOT OK");
		$finish;
	end

endmodule
